[rtl/core/fbc_pkg.sv]
// Shared types, constants and the byte-wide CRC-16/MODBUS step for the frame buffer.
// No dependencies; imported by fbc_crc, the top level and the testbench.
`default_nettype none

package fbc_pkg;

   localparam int unsigned STORE_DEPTH_DEF = 256;

   localparam int unsigned DATA_W      = 8;
   localparam int unsigned FRAME_LEN_W = 8;
   localparam int unsigned CRC_W       = 16;
   localparam int unsigned OPCODE_W    = 3;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [CRC_W-1:0]       CRC_INIT         = 16'hFFFF;
   localparam logic [CRC_W-1:0]       CRC_POLY         = 16'hA001;
   localparam logic [DATA_W-1:0]      EMPTY_POP_BYTE   = 8'hFF;
   localparam logic [FRAME_LEN_W-1:0] MAX_LENGTH_RESET = 8'd255;

   // Register index as decoded from the word address bit.
   localparam logic REG_MAX_LENGTH = 1'b0;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_CLEAR  = 3'd2,
      OP_ENCODE = 3'd3,
      OP_CHECK  = 3'd4
   } opcode_type;

   typedef struct packed {
      logic load_zero;
      logic load_init;
      logic feed;
   } crc_ctrl_type;

   // Fold one byte into the CRC, LSB first.
   function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                 input logic [DATA_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-DATA_W){1'b0}}, data};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[rtl/core/fbc_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module fbc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/fbc_crc.sv]
// CRC-16/MODBUS accumulator: a CRC register that folds in one byte per cycle on feed.
// Depends on fbc_pkg.
`default_nettype none

module fbc_crc
   import fbc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire crc_ctrl_type       ctrl,
   input  wire logic [DATA_W-1:0]  data,
   output logic      [CRC_W-1:0]   crc
);

   logic [CRC_W-1:0] crc_ff;
   logic [CRC_W-1:0] crc_in;

   always_comb begin
      crc_in = crc_ff;
      if (ctrl.load_zero) begin
         crc_in = '0;
      end else if (ctrl.load_init) begin
         crc_in = CRC_INIT;
      end else if (ctrl.feed) begin
         crc_in = crc_step(crc_ff, data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= '0;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_ff;

endmodule

`default_nettype wire

[rtl/core/modbus_frame_buffer_crc_unit.sv]
// Modbus RTU frame buffer with CRC-16/MODBUS generation and check: top level.
// Depends on fbc_pkg, fbc_ram and fbc_crc.
//
// Usage
//   Command channel: drive req_opcode and req_data_byte with start high; the
//   command transfers at the rising edge where start is high and busy is low.
//   Opcodes: push, pop, clear, encode (CRC over all held bytes) and check
//   (CRC over all but the last two bytes, compared low byte first; the two
//   trailing bytes are stripped on a match). Unused codes report status only.
//   Result channel: rsp_valid is high for exactly one cycle per command; the
//   rsp_ ports carry the result in that cycle. The receiver cannot stall, so
//   every result transfers in the cycle it is shown.
//   A command goes from ST_IDLE to ST_PUSH, ST_CLEAR, ST_SHORT or ST_NOP, to
//   ST_POP (then ST_POP_WAIT if a byte is held) for a pop, or to ST_WALK then
//   ST_DONE for encode and check, where the single read port of the frame RAM
//   feeds one byte per cycle into the byte-wide CRC unit.
//   busy stays high until the result is shown; a new command can transfer then.
//   Configuration: APB-style port, max_length at byte address 0, pready tied
//   high; write only while the block is idle.
//   Reset (synchronous): buffer empty, CRC register zero, max_length 255.
//   RAM contents are not cleared; only entries below the fill count are read.
`default_nettype none

module modbus_frame_buffer_crc_unit
   import fbc_pkg::*;
#(
   parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // command channel
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [OPCODE_W-1:0]    req_opcode,
   input  wire logic [DATA_W-1:0]      req_data_byte,
   // result channel
   output logic                        rsp_valid,
   output logic      [DATA_W-1:0]      rsp_read_byte,
   output logic      [CRC_W-1:0]       rsp_crc_value,
   output logic                        rsp_crc_ok,
   output logic                        rsp_accepted,
   output logic      [FRAME_LEN_W-1:0] rsp_frame_length,
   // configuration port
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  paddr,
   input  wire logic [CSR_DATA_W-1:0]  pwdata,
   output logic      [CSR_DATA_W-1:0]  prdata,
   output logic                        pready
);

   localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
   // Physical capacity, one bit wider so that a full-size RAM compares cleanly.
   localparam logic [FRAME_LEN_W:0] DEPTH_LIMIT = (FRAME_LEN_W+1)'(STORE_DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH,
      ST_POP,
      ST_POP_WAIT,
      ST_CLEAR,
      ST_WALK,
      ST_DONE,
      ST_SHORT,
      ST_NOP
   } state_type;

   state_type              state_ff, state_in;
   logic [DATA_W-1:0]      data_ff, data_in;
   logic [FRAME_LEN_W-1:0] fill_ff, fill_in;
   logic [FRAME_LEN_W-1:0] max_length_ff, max_length_in;
   logic [FRAME_LEN_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic                   pend_ff, pend_in;
   logic [FRAME_LEN_W-1:0] pend_idx_ff, pend_idx_in;
   logic [FRAME_LEN_W-1:0] feed_end_ff, feed_end_in;
   logic                   check_ff, check_in;
   logic [DATA_W-1:0]      crc_lo_ff, crc_lo_in;
   logic [DATA_W-1:0]      crc_hi_ff, crc_hi_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]      rsp_read_byte_ff, rsp_read_byte_in;
   logic                   rsp_crc_ok_ff, rsp_crc_ok_in;
   logic                   rsp_accepted_ff, rsp_accepted_in;

   logic                   mem_wr_en;
   logic [ADDR_W-1:0]      mem_wr_addr;
   logic                   mem_rd_en;
   logic [ADDR_W-1:0]      mem_rd_addr;
   logic [DATA_W-1:0]      mem_rd_data;

   crc_ctrl_type           crc_ctrl;
   logic [CRC_W-1:0]       crc_value;

   logic [FRAME_LEN_W-1:0] fill_minus_one;
   logic [FRAME_LEN_W-1:0] fill_minus_two;
   logic                   has_room;
   logic                   csr_write;

   assign fill_minus_one = fill_ff - FRAME_LEN_W'(1);
   assign fill_minus_two = fill_ff - FRAME_LEN_W'(2);
   // A max_length below the fill count only blocks further pushes.
   assign has_room  = (fill_ff < max_length_ff) && ({1'b0, fill_ff} < DEPTH_LIMIT);
   assign csr_write = psel && penable && pwrite && pready;

   fbc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (data_ff),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   fbc_crc u_crc (
      .clock (clock),
      .reset (reset),
      .ctrl  (crc_ctrl),
      .data  (mem_rd_data),
      .crc   (crc_value)
   );

   always_comb begin
      state_in         = state_ff;
      data_in          = data_ff;
      fill_in          = fill_ff;
      max_length_in    = max_length_ff;
      rd_ptr_in        = rd_ptr_ff;
      pend_in          = pend_ff;
      pend_idx_in      = pend_idx_ff;
      feed_end_in      = feed_end_ff;
      check_in         = check_ff;
      crc_lo_in        = crc_lo_ff;
      crc_hi_in        = crc_hi_ff;
      rsp_valid_in     = 1'b0;
      rsp_read_byte_in = '0;
      rsp_crc_ok_in    = 1'b0;
      rsp_accepted_in  = 1'b0;
      mem_wr_en        = 1'b0;
      mem_wr_addr      = fill_ff[ADDR_W-1:0];
      mem_rd_en        = 1'b0;
      mem_rd_addr      = rd_ptr_ff[ADDR_W-1:0];
      crc_ctrl         = '0;

      if (csr_write && (paddr[2] == REG_MAX_LENGTH)) begin
         max_length_in = pwdata[FRAME_LEN_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               data_in   = req_data_byte;
               rd_ptr_in = '0;
               pend_in   = 1'b0;
               case (opcode_type'(req_opcode))
                  OP_PUSH:  state_in = ST_PUSH;
                  OP_POP:   state_in = ST_POP;
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_ENCODE: begin
                     // Feed every held byte.
                     feed_end_in        = fill_ff;
                     check_in           = 1'b0;
                     crc_ctrl.load_init = 1'b1;
                     state_in           = ST_WALK;
                  end
                  OP_CHECK: begin
                     if (fill_ff < FRAME_LEN_W'(2)) begin
                        state_in = ST_SHORT;
                     end else begin
                        // Feed all but the trailing pair, capture the pair.
                        feed_end_in        = fill_minus_two;
                        check_in           = 1'b1;
                        crc_ctrl.load_init = 1'b1;
                        state_in           = ST_WALK;
                     end
                  end
                  default: state_in = ST_NOP;
               endcase
            end
         end

         ST_PUSH: begin
            if (has_room) begin
               mem_wr_en       = 1'b1;
               fill_in         = fill_ff + FRAME_LEN_W'(1);
               rsp_accepted_in = 1'b1;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         ST_POP: begin
            if (fill_ff == '0) begin
               rsp_read_byte_in = EMPTY_POP_BYTE;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = fill_minus_one[ADDR_W-1:0];
               fill_in     = fill_minus_one;
               state_in    = ST_POP_WAIT;
            end
         end

         ST_POP_WAIT: begin
            rsp_read_byte_in = mem_rd_data;
            rsp_valid_in     = 1'b1;
            state_in         = ST_IDLE;
         end

         ST_CLEAR: begin
            fill_in            = '0;
            crc_ctrl.load_zero = 1'b1;
            rsp_valid_in       = 1'b1;
            state_in           = ST_IDLE;
         end

         ST_WALK: begin
            // Issue one read per cycle; fold each byte as its read data returns.
            if (rd_ptr_ff != fill_ff) begin
               mem_rd_en   = 1'b1;
               rd_ptr_in   = rd_ptr_ff + FRAME_LEN_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = rd_ptr_ff;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (pend_idx_ff < feed_end_ff) begin
                  crc_ctrl.feed = 1'b1;
               end else if (pend_idx_ff == feed_end_ff) begin
                  crc_lo_in = mem_rd_data;
               end else begin
                  crc_hi_in = mem_rd_data;
               end
            end
            if ((rd_ptr_ff == fill_ff) && !pend_ff) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            // Low CRC byte comes first in the frame.
            if (check_ff && (crc_lo_ff == crc_value[DATA_W-1:0]) &&
                (crc_hi_ff == crc_value[CRC_W-1:DATA_W])) begin
               rsp_crc_ok_in = 1'b1;
               fill_in       = fill_minus_two;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         ST_SHORT: begin
            // Too short to carry a CRC: report the CRC of no bytes.
            crc_ctrl.load_init = 1'b1;
            rsp_valid_in       = 1'b1;
            state_in           = ST_IDLE;
         end

         ST_NOP: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         max_length_ff <= MAX_LENGTH_RESET;
         rsp_valid_ff  <= 1'b0;
         pend_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         max_length_ff <= max_length_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_ff       <= pend_in;
      end
      data_ff          <= data_in;
      rd_ptr_ff        <= rd_ptr_in;
      pend_idx_ff      <= pend_idx_in;
      feed_end_ff      <= feed_end_in;
      check_ff         <= check_in;
      crc_lo_ff        <= crc_lo_in;
      crc_hi_ff        <= crc_hi_in;
      rsp_read_byte_ff <= rsp_read_byte_in;
      rsp_crc_ok_ff    <= rsp_crc_ok_in;
      rsp_accepted_ff  <= rsp_accepted_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_byte    = rsp_read_byte_ff;
   assign rsp_crc_value    = crc_value;
   assign rsp_crc_ok       = rsp_crc_ok_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_frame_length = fill_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_MAX_LENGTH) ?
                   {{(CSR_DATA_W-FRAME_LEN_W){1'b0}}, max_length_ff} : '0;

endmodule

`default_nettype wire

[sim/tb_modbus_frame_buffer_crc_unit.sv]
// Self-checking testbench for the Modbus frame buffer with CRC-16/MODBUS check.
// Drives directed and random commands and max_length writes, and compares every
// result with a built-in prediction. Depends on fbc_pkg and the block's RTL.

module tb_modbus_frame_buffer_crc_unit;
   import fbc_pkg::*;

   localparam int CLOCK_PERIOD  = 4;
   localparam int RESET_CYCLES  = 12;
   localparam int IDLE_PERCENT  = 24;
   // Longest honest silence is an encode or check over 255 bytes.
   localparam int QUIET_LIMIT   = 4000;
   localparam int TAIL_CYCLES   = 270;
   localparam int DIRECTED_ROWS = 25;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 166;
   localparam int DEEP_PHASE    = 4;
   localparam int QUIET_PHASE   = 6;

   // Codes 5 to 7 are not decoded; they only report status.
   localparam logic [OPCODE_W-1:0] OP_SPARE_LOW  = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_SPARE_MID  = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_HIGH = 3'd7;

   // max_length is register 0, so it sits at byte address 0.
   localparam logic [CSR_ADDR_W-1:0] MAX_LENGTH_ADDR = {REG_MAX_LENGTH, 2'b00};

   typedef struct packed {
      logic [DATA_W-1:0]      read_byte;
      logic [CRC_W-1:0]       crc_value;
      logic                   crc_ok;
      logic                   accepted;
      logic [FRAME_LEN_W-1:0] frame_length;
   } frame_result_type;

   // One row of the directed table: either a command or a max_length write.
   typedef struct packed {
      logic                  is_csr;
      logic [OPCODE_W-1:0]   opcode;
      logic [DATA_W-1:0]     value;
      logic                  typed;
      frame_result_type      want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [OPCODE_W-1:0]    req_opcode = '0;
   logic [DATA_W-1:0]      req_data_byte = '0;
   logic                   rsp_valid;
   logic [DATA_W-1:0]      rsp_read_byte;
   logic [CRC_W-1:0]       rsp_crc_value;
   logic                   rsp_crc_ok;
   logic                   rsp_accepted;
   logic [FRAME_LEN_W-1:0] rsp_frame_length;
   logic                   psel = 1'b0;
   logic                   penable = 1'b0;
   logic                   pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  paddr = '0;
   logic [CSR_DATA_W-1:0]  pwdata = '0;
   logic [CSR_DATA_W-1:0]  prdata;
   logic                   pready;

   // Shadow of the block: held bytes, fill count, CRC register and max_length.
   logic [DATA_W-1:0]      frame_bytes [0:STORE_DEPTH_DEF-1];
   int unsigned            frame_fill = 0;
   logic [CRC_W-1:0]       crc_reg = '0;
   logic [FRAME_LEN_W-1:0] max_len = MAX_LENGTH_RESET;

   frame_result_type expected_results [$];
   int               mismatch_count = 0;
   int               quiet_cycles = 0;
   int unsigned      items_sent = 0;
   bit               idle_enable = 1'b1;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   modbus_frame_buffer_crc_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_read_byte    (rsp_read_byte),
      .rsp_crc_value    (rsp_crc_value),
      .rsp_crc_ok       (rsp_crc_ok),
      .rsp_accepted     (rsp_accepted),
      .rsp_frame_length (rsp_frame_length),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // Directed table. Typed rows carry a result that is plain from the opcode;
   // the others take the prediction. The frame 01 03 00 00 00 01 is the usual
   // read-holding-register request, whose CRC is 0x0A84 (sent as 84 0A).
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{1'b0, OP_POP,        8'h5A, 1'b1, '{8'hFF, 16'h0000, 1'b0, 1'b0, 8'd0}},
      '{1'b0, OP_CHECK,      8'hC3, 1'b1, '{8'h00, 16'hFFFF, 1'b0, 1'b0, 8'd0}},
      '{1'b0, OP_ENCODE,     8'h3C, 1'b1, '{8'h00, 16'hFFFF, 1'b0, 1'b0, 8'd0}},
      '{1'b0, OP_PUSH,       8'h00, 1'b1, '{8'h00, 16'hFFFF, 1'b0, 1'b1, 8'd1}},
      '{1'b0, OP_CHECK,      8'hFF, 1'b1, '{8'h00, 16'hFFFF, 1'b0, 1'b0, 8'd1}},
      '{1'b0, OP_PUSH,       8'hFF, 1'b0, '0},
      '{1'b0, OP_ENCODE,     8'h81, 1'b0, '0},
      '{1'b0, OP_POP,        8'h18, 1'b0, '0},
      '{1'b0, OP_SPARE_LOW,  8'hAA, 1'b0, '0},
      '{1'b0, OP_SPARE_MID,  8'h55, 1'b0, '0},
      '{1'b0, OP_SPARE_HIGH, 8'hFF, 1'b0, '0},
      '{1'b0, OP_CLEAR,      8'h7E, 1'b1, '{8'h00, 16'h0000, 1'b0, 1'b0, 8'd0}},
      '{1'b0, OP_PUSH,       8'h01, 1'b0, '0},
      '{1'b0, OP_PUSH,       8'h03, 1'b0, '0},
      '{1'b0, OP_PUSH,       8'h00, 1'b0, '0},
      '{1'b0, OP_PUSH,       8'h00, 1'b0, '0},
      '{1'b0, OP_PUSH,       8'h00, 1'b0, '0},
      '{1'b0, OP_PUSH,       8'h01, 1'b0, '0},
      '{1'b0, OP_ENCODE,     8'h00, 1'b1, '{8'h00, 16'h0A84, 1'b0, 1'b0, 8'd6}},
      '{1'b0, OP_PUSH,       8'h84, 1'b0, '0},
      '{1'b0, OP_PUSH,       8'h0A, 1'b0, '0},
      '{1'b0, OP_CHECK,      8'h66, 1'b1, '{8'h00, 16'h0A84, 1'b1, 1'b0, 8'd6}},
      // Shrink the store to exactly its fill: the next push must be dropped.
      '{1'b1, OP_PUSH,       8'd6,  1'b0, '0},
      '{1'b0, OP_PUSH,       8'h77, 1'b1, '{8'h00, 16'h0A84, 1'b0, 1'b0, 8'd6}},
      // Trailing bytes 00 01 do not match the CRC of 01 03 00 00: check fails.
      '{1'b0, OP_CHECK,      8'h99, 1'b0, '0}
   };

   // CRC-16/MODBUS over the first count held bytes, LSB first.
   function automatic logic [CRC_W-1:0] modbus_crc(input int unsigned count);
      logic [CRC_W-1:0] c;
      c = CRC_INIT;
      for (int i = 0; i < count && i < STORE_DEPTH_DEF; i++) begin
         c = c ^ {8'h00, frame_bytes[i]};
         for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         end
      end
      return c;
   endfunction

   // Remove the last held byte; the vacated entry returns to zero.
   function automatic logic [DATA_W-1:0] take_top();
      logic [DATA_W-1:0] v;
      if (frame_fill == 0) begin
         return EMPTY_POP_BYTE;
      end
      frame_fill--;
      v = frame_bytes[frame_fill];
      frame_bytes[frame_fill] = '0;
      return v;
   endfunction

   // Advance the shadow by one command and return the result it must give.
   function automatic frame_result_type frame_apply(input logic [OPCODE_W-1:0] op,
                                                    input logic [DATA_W-1:0] data);
      frame_result_type r;
      r = '0;
      case (op)
         OP_PUSH: begin
            // max_length is 8 bits, so it never exceeds the store depth.
            if (frame_fill < max_len) begin
               frame_bytes[frame_fill] = data;
               frame_fill++;
               r.accepted = 1'b1;
            end
         end
         OP_POP: begin
            r.read_byte = take_top();
         end
         OP_CLEAR: begin
            for (int i = 0; i < STORE_DEPTH_DEF; i++) begin
               frame_bytes[i] = '0;
            end
            frame_fill = 0;
            crc_reg = '0;
         end
         OP_ENCODE: begin
            crc_reg = modbus_crc(frame_fill);
         end
         OP_CHECK: begin
            if (frame_fill < 2) begin
               crc_reg = CRC_INIT;
            end else begin
               crc_reg = modbus_crc(frame_fill - 2);
               // Low CRC byte comes first on the wire.
               if (frame_bytes[frame_fill-2] == crc_reg[7:0] &&
                   frame_bytes[frame_fill-1] == crc_reg[15:8]) begin
                  void'(take_top());
                  void'(take_top());
                  r.crc_ok = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      r.crc_value = crc_reg;
      r.frame_length = FRAME_LEN_W'(frame_fill);
      return r;
   endfunction

   // Present one command and hold it until it transfers. Idle cycles go in
   // front of it at random; the inputs carry noise while start is low.
   task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic [DATA_W-1:0] data,
                           input bit use_typed = 1'b0,
                           input frame_result_type typed = '0);
      frame_result_type predicted;
      @(negedge clock);
      while (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
         start = 1'b0;
         req_opcode = OPCODE_W'($urandom_range(OP_SPARE_HIGH));
         req_data_byte = DATA_W'($urandom);
         @(negedge clock);
      end
      start = 1'b1;
      req_opcode = op;
      req_data_byte = data;
      do begin
         @(posedge clock);
      end while (busy);
      predicted = frame_apply(op, data);
      expected_results.push_back(use_typed ? typed : predicted);
      items_sent++;
   endtask

   // Drop start and wait until every outstanding result has arrived.
   task automatic settle_idle();
      @(negedge clock);
      start = 1'b0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // APB write of max_length: setup cycle, then access until pready.
   task automatic write_max_length(input logic [FRAME_LEN_W-1:0] value);
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = MAX_LENGTH_ADDR;
      pwdata = CSR_DATA_W'(value);
      @(negedge clock);
      penable = 1'b1;
      do begin
         @(posedge clock);
      end while (!pready);
      max_len = value;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   // A well-formed frame with random content: optional clear, pushes, optional
   // encode, CRC trailer (at times corrupted), optional pop, check, up to two pops.
   task automatic frame_sequence();
      int unsigned      count;
      logic [CRC_W-1:0] trailer;
      if ($urandom_range(3) == 0) begin
         send_cmd(OP_CLEAR, DATA_W'($urandom));
      end
      count = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(12);
      repeat (count) send_cmd(OP_PUSH, DATA_W'($urandom));
      if ($urandom_range(1) == 0) begin
         send_cmd(OP_ENCODE, DATA_W'($urandom));
      end
      trailer = modbus_crc(frame_fill);
      if ($urandom_range(4) == 0) begin
         trailer[$urandom_range(CRC_W - 1)] ^= 1'b1;
      end
      send_cmd(OP_PUSH, trailer[7:0]);
      send_cmd(OP_PUSH, trailer[15:8]);
      if ($urandom_range(7) == 0) begin
         send_cmd(OP_POP, DATA_W'($urandom));
      end
      send_cmd(OP_CHECK, DATA_W'($urandom));
      repeat ($urandom_range(2)) send_cmd(OP_POP, DATA_W'($urandom));
   endtask

   task automatic report_field(input string name, input logic [CRC_W-1:0] want,
                               input logic [CRC_W-1:0] seen);
      if (want !== seen) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
         mismatch_count++;
      end
   endtask

   // Each result transfers in the cycle it is shown; sample it at the edge
   // that ends that cycle and compare with the oldest prediction.
   always @(posedge clock) begin : result_monitor
      frame_result_type seen;
      frame_result_type want;
      if (!reset && rsp_valid) begin
         seen = '{rsp_read_byte, rsp_crc_value, rsp_crc_ok, rsp_accepted,
                  rsp_frame_length};
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, seen);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            report_field("read_byte", CRC_W'(want.read_byte), CRC_W'(seen.read_byte));
            report_field("crc_value", want.crc_value, seen.crc_value);
            report_field("crc_ok", CRC_W'(want.crc_ok), CRC_W'(seen.crc_ok));
            report_field("accepted", CRC_W'(want.accepted), CRC_W'(seen.accepted));
            report_field("frame_length", CRC_W'(want.frame_length),
                         CRC_W'(seen.frame_length));
         end
      end
   end

   // Watchdog: count cycles with no transfer on either channel.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: timeout after %0d quiet cycles", $time, quiet_cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin : stimulus
      logic [FRAME_LEN_W-1:0] phase_lengths [PHASES];
      logic [CRC_W-1:0]       trailer;
      // Extremes first, then a random value, a mid one, and back to full size.
      phase_lengths = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd255, 8'd0, 8'd12, 8'd255};
      phase_lengths[5] = FRAME_LEN_W'($urandom_range(4, 40));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Walk the directed table.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            settle_idle();
            write_max_length(directed_rows[i].value);
         end else begin
            send_cmd(directed_rows[i].opcode, directed_rows[i].value,
                     directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // Random phases, each under its own max_length. Leftover bytes carry
      // over, so a smaller limit can fall below the current fill.
      for (int p = 0; p < PHASES; p++) begin
         settle_idle();
         write_max_length(phase_lengths[p]);
         idle_enable = (p != QUIET_PHASE);
         if (p == DEEP_PHASE) begin
            // Fill the store to 255 bytes, overflow it, encode and check it, then
            // strip two bytes and close the frame with a matching trailer.
            send_cmd(OP_CLEAR, DATA_W'($urandom));
            repeat (STORE_DEPTH_DEF) send_cmd(OP_PUSH, DATA_W'($urandom));
            send_cmd(OP_ENCODE, DATA_W'($urandom));
            send_cmd(OP_CHECK, DATA_W'($urandom));
            send_cmd(OP_POP, DATA_W'($urandom));
            send_cmd(OP_POP, DATA_W'($urandom));
            trailer = modbus_crc(frame_fill);
            send_cmd(OP_PUSH, trailer[7:0]);
            send_cmd(OP_PUSH, trailer[15:8]);
            send_cmd(OP_CHECK, DATA_W'($urandom));
         end
         while (items_sent < DIRECTED_ROWS + (p + 1) * PHASE_ITEMS) begin
            if ($urandom_range(99) < 65) begin
               frame_sequence();
            end else begin
               send_cmd(OPCODE_W'($urandom_range(OP_SPARE_HIGH)), DATA_W'($urandom));
            end
         end
      end

      // Drain, then allow for a stray late result before deciding.
      settle_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0t: %0d results missing, expected %h, actual none", $time,
                  expected_results.size(), expected_results[0]);
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
